// File: design/mbdp_pkg.sv
package mbdp_pkg;

    typedef enum logic [3:0] {
        PH_TOP_HDR,
        PH_TOP_SKIP,
        PH_MOOV_HDR,
        PH_CHILD_SKIP,
        PH_MVHD,
        PH_MVEX_HDR,
        PH_MVEX_SKIP,
        PH_MEHD,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_MUL,
        SQ_DIV,
        SQ_OUT
    } t_seq;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NO_MOOV   = 2'd1,
        ST_TS_ZERO   = 2'd2,
        ST_OVER      = 2'd3
    } t_status;

    localparam logic [31:0] TAG_MOOV = 32'h6D6F6F76;
    localparam logic [31:0] TAG_MVHD = 32'h6D766864;
    localparam logic [31:0] TAG_MVEX = 32'h6D766578;
    localparam logic [31:0] TAG_MEHD = 32'h6D656864;

    localparam logic [31:0] MAX_DURATION_RESET = 32'd86400000;
    localparam int          DIV_STEPS          = 64;

endpackage

// File: design/mp4_box_duration_parser_unit.sv
// channel | dir | beat content
// s       | in  | tdata[7:0] file byte, tlast marks final byte of file
// m       | out | tdata[31:0] duration in ms, tuser[1:0] status
// cfg     | in  | wdata[31:0] max duration in ms, taken when we is high
// a byte that produces no result leaves the input ready to take the next byte
// a byte that ends the parse with a computed result goes through one multiply by 1000
// (shift and subtract), 64 steps of the shared restoring divider and one limit compare
// results with a fixed value (no moov or bad top box, timescale zero) are registered as the byte is taken
// i_rst_n is synchronous, active low; it clears the parser and sets the limit to 86400000
// input is held off while the divider runs or while an undelivered result blocks a new one
module mp4_box_duration_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] duration_ms
    output logic [1:0]  o_m_tuser,   // [1:0] status
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import mbdp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hidx, n_hidx;
    logic [63:0] r_size, n_size;
    logic [31:0] r_type, n_type;
    logic [63:0] r_top, n_top;
    logic [63:0] r_moov, n_moov;
    logic [63:0] r_child, n_child;
    logic [63:0] r_mvex, n_mvex;
    logic [5:0]  r_body, n_body;
    logic        r_wide, n_wide;
    logic [31:0] r_ts, n_ts;
    logic [63:0] r_mdur, n_mdur;
    logic [63:0] r_fdur, n_fdur;
    logic        r_sent, n_sent;

    logic [31:0] r_max;

    t_seq        r_seq, n_seq;
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;

    logic        r_out_valid;
    logic [31:0] r_out_ms;
    t_status     r_out_st;

    logic        accept;
    logic        emit_fix;
    logic        emit_comp;
    t_status     emit_st;
    logic        out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_seq == SQ_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_ms;
    assign o_m_tuser  = r_out_st;

    // per-byte parser step
    always_comb begin
        logic [7:0]  b;
        logic [4:0]  i;
        logic [5:0]  o;
        logic [63:0] sz;
        logic [63:0] hl;
        logic        wd;
        logic [5:0]  flen;
        logic        do_after;
        logic        early;
        n_phase = r_phase; n_hidx = r_hidx; n_size = r_size; n_type = r_type;
        n_top = r_top; n_moov = r_moov; n_child = r_child; n_mvex = r_mvex;
        n_body = r_body; n_wide = r_wide; n_ts = r_ts; n_mdur = r_mdur;
        n_fdur = r_fdur; n_sent = r_sent;
        emit_fix = 1'b0; emit_comp = 1'b0; emit_st = ST_FOUND;
        b = i_s_tdata; i = r_hidx; o = r_body;
        sz = '0; hl = '0; wd = 1'b0; flen = '0; do_after = 1'b0; early = 1'b0;
        case (r_phase)
            PH_TOP_HDR: begin
                if (i < 5'd4) begin
                    n_size = (i == 5'd0) ? {56'd0, b} : {r_size[55:0], b};
                end else if (i < 5'd8) begin
                    n_type = {r_type[23:0], b};
                end else begin
                    n_size = (i == 5'd8) ? {56'd0, b} : {r_size[55:0], b};
                end
                n_hidx = i + 5'd1;
                if (!(i == 5'd7 && n_size == 64'd1) && (i == 5'd7 || i == 5'd15)) begin
                    hl = (i == 5'd15) ? 64'd16 : 64'd8;
                    n_hidx = '0;
                    if (n_size < hl) begin
                        emit_fix = 1'b1;
                        emit_st  = ST_NO_MOOV;
                    end else if (n_type == TAG_MOOV) begin
                        n_moov   = n_size - hl;
                        do_after = 1'b1;
                    end else begin
                        n_top   = n_size - hl;
                        n_phase = (n_top != 64'd0) ? PH_TOP_SKIP : PH_TOP_HDR;
                    end
                end
            end
            PH_TOP_SKIP: begin
                n_top = r_top - 64'd1;
                if (n_top == 64'd0) n_phase = PH_TOP_HDR;
            end
            PH_MOOV_HDR: begin
                if (i < 5'd4) begin
                    n_size = (i == 5'd0) ? {56'd0, b} : {r_size[55:0], b};
                end else begin
                    n_type = {r_type[23:0], b};
                end
                n_hidx = i + 5'd1;
                if (i == 5'd7) begin
                    n_hidx = '0;
                    sz = {32'd0, n_size[31:0]};
                    if (sz < 64'd8 || sz > r_moov) begin
                        emit_comp = 1'b1;
                    end else begin
                        n_moov  = r_moov - sz;
                        n_child = sz - 64'd8;
                        if (n_child == 64'd0) begin
                            do_after = 1'b1;
                        end else begin
                            n_body = '0;
                            if (n_type == TAG_MVHD) begin
                                n_phase = PH_MVHD;
                            end else if (n_type == TAG_MVEX) begin
                                n_mvex = n_child;
                                if (n_mvex >= 64'd8) begin
                                    n_phase = PH_MVEX_HDR;
                                    n_hidx  = '0;
                                end else begin
                                    n_phase = PH_CHILD_SKIP;
                                end
                            end else begin
                                n_phase = PH_CHILD_SKIP;
                            end
                        end
                    end
                end
            end
            PH_CHILD_SKIP, PH_MVHD, PH_MVEX_HDR, PH_MVEX_SKIP, PH_MEHD: begin
                case (r_phase)
                    PH_MVHD: begin
                        wd = (o == 6'd0) ? (b == 8'd1) : r_wide;
                        n_wide = wd;
                        if (wd) begin
                            if (o >= 6'd20 && o <= 6'd23) begin
                                n_size = (o == 6'd20) ? {56'd0, b} : {r_size[55:0], b};
                                if (o == 6'd23) n_ts = n_size[31:0];
                            end
                            if (o >= 6'd24 && o <= 6'd31) begin
                                n_size = (o == 6'd24) ? {56'd0, b} : {r_size[55:0], b};
                                if (o == 6'd31) n_mdur = n_size;
                            end
                        end else begin
                            if (o >= 6'd12 && o <= 6'd15) begin
                                n_size = (o == 6'd12) ? {56'd0, b} : {r_size[55:0], b};
                                if (o == 6'd15) n_ts = n_size[31:0];
                            end
                            if (o >= 6'd16 && o <= 6'd19) begin
                                n_size = (o == 6'd16) ? {56'd0, b} : {r_size[55:0], b};
                                if (o == 6'd19) n_mdur = {32'd0, n_size[31:0]};
                            end
                        end
                        if (o >= 6'd31) n_phase = PH_CHILD_SKIP;
                    end
                    PH_MVEX_HDR: begin
                        if (i < 5'd4) begin
                            n_size = (i == 5'd0) ? {56'd0, b} : {r_size[55:0], b};
                        end else begin
                            n_type = {r_type[23:0], b};
                        end
                        n_hidx = i + 5'd1;
                        if (i == 5'd7) begin
                            n_hidx = '0;
                            sz = {32'd0, n_size[31:0]};
                            if (sz < 64'd8 || sz > r_mvex) begin
                                n_phase = PH_CHILD_SKIP;
                            end else if (n_type == TAG_MEHD) begin
                                n_top   = sz - 64'd8;
                                n_body  = '0;
                                n_phase = (n_top != 64'd0) ? PH_MEHD : PH_CHILD_SKIP;
                                n_child = r_child - 64'd1;
                                early   = 1'b1;
                                if (n_child == 64'd0) do_after = 1'b1;
                            end else begin
                                n_mvex = r_mvex - sz;
                                n_top  = sz - 64'd8;
                                if (n_top != 64'd0) begin
                                    n_phase = PH_MVEX_SKIP;
                                end else if (n_mvex >= 64'd8) begin
                                    n_phase = PH_MVEX_HDR;
                                end else begin
                                    n_phase = PH_CHILD_SKIP;
                                end
                            end
                        end
                    end
                    PH_MVEX_SKIP: begin
                        n_top = r_top - 64'd1;
                        if (n_top == 64'd0) begin
                            if (r_mvex >= 64'd8) begin
                                n_phase = PH_MVEX_HDR;
                                n_hidx  = '0;
                            end else begin
                                n_phase = PH_CHILD_SKIP;
                            end
                        end
                    end
                    PH_MEHD: begin
                        wd = (o == 6'd0) ? (b == 8'd1) : r_wide;
                        n_wide = wd;
                        flen = wd ? 6'd8 : 6'd4;
                        if (o >= 6'd4 && o < 6'd4 + flen) begin
                            n_size = (o == 6'd4) ? {56'd0, b} : {r_size[55:0], b};
                            if (o == 6'd3 + flen) begin
                                n_fdur  = wd ? n_size : {32'd0, n_size[31:0]};
                                n_phase = PH_CHILD_SKIP;
                            end
                        end
                        n_top = r_top - 64'd1;
                        if (n_top == 64'd0) n_phase = PH_CHILD_SKIP;
                    end
                    default: begin
                    end
                endcase
                if (!early) begin
                    if (r_body < 6'd63) n_body = n_body + 6'd1;
                    n_child = r_child - 64'd1;
                    if (n_child == 64'd0) do_after = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (do_after) begin
            if (n_moov >= 64'd8) begin
                n_phase = PH_MOOV_HDR;
                n_hidx  = '0;
            end else begin
                emit_comp = 1'b1;
            end
        end
        if (emit_fix || emit_comp) begin
            n_phase = PH_DONE;
            n_sent  = 1'b1;
        end
        if (i_s_tlast) begin
            if (!n_sent) begin
                if (n_phase >= PH_MOOV_HDR && n_phase <= PH_MEHD) begin
                    emit_comp = 1'b1;
                end else begin
                    emit_fix = 1'b1;
                    emit_st  = ST_NO_MOOV;
                end
            end
            // end of file clears the parser
            n_phase = PH_TOP_HDR; n_hidx = '0; n_size = '0; n_type = '0;
            n_top = '0; n_moov = '0; n_child = '0; n_mvex = '0; n_body = '0;
            n_wide = 1'b0; n_sent = 1'b0;
        end
        // timescale zero needs no divide
        if (emit_comp && n_ts == 32'd0) begin
            emit_comp = 1'b0;
            emit_fix  = 1'b1;
            emit_st   = ST_TS_ZERO;
        end
    end

    // operands captured before the end-of-file clear
    logic [31:0] cap_ts;
    logic [63:0] cap_dur;
    always_comb begin
        cap_ts  = n_ts;
        cap_dur = (n_mdur != 64'd0) ? n_mdur : n_fdur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOP_HDR; r_hidx <= '0; r_size <= '0; r_type <= '0;
            r_top <= '0; r_moov <= '0; r_child <= '0; r_mvex <= '0; r_body <= '0;
            r_wide <= 1'b0; r_ts <= '0; r_mdur <= '0; r_fdur <= '0; r_sent <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase; r_hidx <= n_hidx; r_size <= n_size; r_type <= n_type;
            r_top <= n_top; r_moov <= n_moov; r_child <= n_child; r_mvex <= n_mvex;
            r_body <= n_body; r_wide <= n_wide; r_sent <= n_sent;
            if (i_s_tlast) begin
                r_ts <= '0; r_mdur <= '0; r_fdur <= '0;
            end else begin
                r_ts <= n_ts; r_mdur <= n_mdur; r_fdur <= n_fdur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_DURATION_RESET;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    // divide sequencer: next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SQ_IDLE: if (accept && emit_comp) n_seq = SQ_MUL;
            SQ_MUL:  n_seq = SQ_DIV;
            SQ_DIV:  if (r_cnt == 6'(DIV_STEPS - 1)) n_seq = SQ_OUT;
            SQ_OUT:  if (out_free) n_seq = SQ_IDLE;
            default: n_seq = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    // shared restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        logic [32:0] rsh;
        rsh = {r_rem[31:0], r_q[63]};
        case (r_seq)
            SQ_IDLE: begin
                if (accept && emit_comp) begin
                    r_q   <= cap_dur;
                    r_div <= cap_ts;
                end
                r_cnt <= '0;
            end
            SQ_MUL: begin
                // x*1000 = x*1024 - x*16 - x*8, modulo 2^64
                r_q   <= (r_q << 10) - (r_q << 4) - (r_q << 3);
                r_rem <= '0;
            end
            SQ_DIV: begin
                if (rsh >= {1'b0, r_div}) begin
                    r_rem <= rsh - {1'b0, r_div};
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= rsh;
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit_fix) begin
            r_out_valid <= 1'b1;
        end else if (r_seq == SQ_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit_fix) begin
            r_out_ms <= '0;
            r_out_st <= emit_st;
        end else if (r_seq == SQ_OUT && out_free) begin
            if (r_q > {32'd0, r_max}) begin
                r_out_ms <= '0;
                r_out_st <= ST_OVER;
            end else begin
                r_out_ms <= r_q[31:0];
                r_out_st <= ST_FOUND;
            end
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SQ_IDLE) |-> !o_s_tready)
        else $error("input taken while divider busy");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_DIV) |-> (r_div != 32'd0))
        else $error("divide by zero timescale");

    a_mul_then_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_MUL) |=> (r_seq == SQ_DIV && r_cnt == 6'd0))
        else $error("divider start lost");

    a_fixed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_FOUND) |-> (o_m_tdata == 32'd0))
        else $error("nonzero duration with error status");

endmodule

// File: test/mp4_box_duration_parser_unit_test.sv
module mp4_box_duration_parser_unit_test;
    import mbdp_pkg::*;

    typedef logic [7:0] bq_t[$];

    typedef struct packed {
        logic [31:0] ms;
        logic [1:0]  st;
    } dur_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    mp4_box_duration_parser_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [7:0] data_byte
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [31:0] duration_ms
        .o_m_tuser   (o_m_tuser),   // [1:0] status
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // parser mirror
    t_phase      ph;
    logic [4:0]  hidx;
    logic [63:0] acc;
    logic [31:0] tag;
    logic [63:0] top_left, moov_left, child_left, mvex_left;
    logic [5:0]  boff;
    logic        wide;
    logic [31:0] tscale;
    logic [63:0] mdur, fdur;
    logic        sent;
    logic [31:0] limit_ms;

    dur_result_t dur_expected[$];
    int          errors = 0;
    int          bytes_sent = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    always #1 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic clear_parser();
        ph = PH_TOP_HDR; hidx = 0; acc = 0; tag = 0;
        top_left = 0; moov_left = 0; child_left = 0; mvex_left = 0;
        boff = 0; wide = 0; tscale = 0; mdur = 0; fdur = 0; sent = 0;
    endtask

    task automatic post_result(input logic [31:0] ms, input logic [1:0] st);
        dur_expected.push_back('{ms: ms, st: st});
        sent = 1;
        ph = PH_DONE;
    endtask

    task automatic post_computed();
        logic [63:0] d, prod, q;
        if (tscale == 0) begin
            post_result(0, ST_TS_ZERO);
        end else begin
            d = (mdur != 0) ? mdur : fdur;
            prod = d * 64'd1000;
            q = prod / {32'd0, tscale};
            if (q > {32'd0, limit_ms}) post_result(0, ST_OVER);
            else post_result(q[31:0], ST_FOUND);
        end
    endtask

    task automatic after_child();
        if (moov_left >= 8) begin
            ph = PH_MOOV_HDR;
            hidx = 0;
        end else begin
            post_computed();
        end
    endtask

    task automatic next_mvex_hdr();
        if (mvex_left >= 8) begin
            ph = PH_MVEX_HDR;
            hidx = 0;
        end else begin
            ph = PH_CHILD_SKIP;
        end
    endtask

    function automatic bit take_field(input int o, input int first, input int len,
                                      input logic [7:0] b);
        if (o < first || o >= first + len) return 0;
        acc = (o == first) ? {56'd0, b} : {acc[55:0], b};
        return o == first + len - 1;
    endfunction

    task automatic top_header(input logic [7:0] b);
        int i;
        logic [63:0] hl;
        i = hidx;
        if (i < 4) acc = (i == 0) ? {56'd0, b} : {acc[55:0], b};
        else if (i < 8) tag = {tag[23:0], b};
        else acc = (i == 8) ? {56'd0, b} : {acc[55:0], b};
        hidx = hidx + 1;
        if (i == 7 && acc == 1) return;
        if (i != 7 && i != 15) return;
        hl = (i == 15) ? 16 : 8;
        hidx = 0;
        if (acc < hl) begin
            post_result(0, ST_NO_MOOV);
        end else if (tag == TAG_MOOV) begin
            moov_left = acc - hl;
            after_child();
        end else begin
            top_left = acc - hl;
            ph = (top_left != 0) ? PH_TOP_SKIP : PH_TOP_HDR;
        end
    endtask

    task automatic moov_header(input logic [7:0] b);
        int i;
        logic [63:0] sz;
        i = hidx;
        if (i < 4) acc = (i == 0) ? {56'd0, b} : {acc[55:0], b};
        else tag = {tag[23:0], b};
        hidx = hidx + 1;
        if (i < 7) return;
        hidx = 0;
        sz = {32'd0, acc[31:0]};
        if (sz < 8 || sz > moov_left) begin
            post_computed();
            return;
        end
        moov_left -= sz;
        child_left = sz - 8;
        if (child_left == 0) begin
            after_child();
            return;
        end
        boff = 0;
        if (tag == TAG_MVHD) begin
            ph = PH_MVHD;
        end else if (tag == TAG_MVEX) begin
            mvex_left = child_left;
            next_mvex_hdr();
        end else begin
            ph = PH_CHILD_SKIP;
        end
    endtask

    task automatic child_body(input logic [7:0] b);
        int o, i;
        logic [63:0] sz;
        o = boff;
        case (ph)
            PH_MVHD: begin
                if (o == 0) wide = (b == 1);
                if (wide) begin
                    if (take_field(o, 20, 4, b)) tscale = acc[31:0];
                    if (take_field(o, 24, 8, b)) mdur = acc;
                end else begin
                    if (take_field(o, 12, 4, b)) tscale = acc[31:0];
                    if (take_field(o, 16, 4, b)) mdur = {32'd0, acc[31:0]};
                end
                if (o >= 31) ph = PH_CHILD_SKIP;
            end
            PH_MVEX_HDR: begin
                i = hidx;
                if (i < 4) acc = (i == 0) ? {56'd0, b} : {acc[55:0], b};
                else tag = {tag[23:0], b};
                hidx = hidx + 1;
                if (i == 7) begin
                    hidx = 0;
                    sz = {32'd0, acc[31:0]};
                    if (sz < 8 || sz > mvex_left) begin
                        ph = PH_CHILD_SKIP;
                    end else if (tag == TAG_MEHD) begin
                        // mehd header ends the byte early: no offset advance
                        top_left = sz - 8;
                        boff = 0;
                        ph = (top_left != 0) ? PH_MEHD : PH_CHILD_SKIP;
                        child_left--;
                        if (child_left == 0) after_child();
                        return;
                    end else begin
                        mvex_left -= sz;
                        top_left = sz - 8;
                        if (top_left != 0) ph = PH_MVEX_SKIP;
                        else next_mvex_hdr();
                    end
                end
            end
            PH_MVEX_SKIP: begin
                top_left--;
                if (top_left == 0) next_mvex_hdr();
            end
            PH_MEHD: begin
                if (o == 0) wide = (b == 1);
                if (take_field(o, 4, wide ? 8 : 4, b)) begin
                    fdur = wide ? acc : {32'd0, acc[31:0]};
                    ph = PH_CHILD_SKIP;
                end
                top_left--;
                if (top_left == 0) ph = PH_CHILD_SKIP;
            end
            default: ;
        endcase
        if (boff < 63) boff++;
        child_left--;
        if (child_left == 0) after_child();
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        case (ph)
            PH_TOP_HDR: top_header(b);
            PH_TOP_SKIP: begin
                top_left--;
                if (top_left == 0) ph = PH_TOP_HDR;
            end
            PH_MOOV_HDR: moov_header(b);
            PH_CHILD_SKIP, PH_MVHD, PH_MVEX_HDR, PH_MVEX_SKIP, PH_MEHD: child_body(b);
            default: ;
        endcase
        if (last) begin
            if (!sent) begin
                if (ph >= PH_MOOV_HDR && ph <= PH_MEHD) post_computed();
                else post_result(0, ST_NO_MOOV);
            end
            clear_parser();
        end
    endtask

    // file builders
    function automatic bq_t be(input logic [63:0] v, input int n);
        bq_t r;
        for (int k = n - 1; k >= 0; k--) r.push_back(v[8*k +: 8]);
        return r;
    endfunction

    function automatic bq_t rnd_bytes(input int n);
        bq_t r;
        repeat (n) r.push_back($urandom_range(0, 255));
        return r;
    endfunction

    function automatic bq_t mk_box(input logic [31:0] t, input bq_t body, input bit ext);
        if (ext) return {be(1, 4), be({32'd0, t}, 4), be(64'(body.size() + 16), 8), body};
        return {be(64'(body.size() + 8), 4), be({32'd0, t}, 4), body};
    endfunction

    function automatic bq_t mk_mvhd(input logic [7:0] ver, input logic [31:0] ts,
                                    input logic [63:0] d, input int len);
        bq_t body;
        body = rnd_bytes(32);
        body[0] = ver;
        for (int k = 0; k < 4; k++) begin
            if (ver == 1) body[20 + k] = ts[8*(3-k) +: 8];
            else body[12 + k] = ts[8*(3-k) +: 8];
        end
        for (int k = 0; k < 8; k++) begin
            if (ver == 1) body[24 + k] = d[8*(7-k) +: 8];
            else if (k < 4) body[16 + k] = d[8*(3-k) +: 8];
        end
        while (body.size() > len) body.pop_back();
        while (body.size() < len) body.push_back($urandom_range(0, 255));
        return mk_box(TAG_MVHD, body, 0);
    endfunction

    function automatic bq_t mk_mehd(input logic [7:0] ver, input logic [63:0] d,
                                    input int len);
        bq_t body;
        body = rnd_bytes(12);
        body[0] = ver;
        for (int k = 0; k < 8; k++) begin
            if (ver == 1) body[4 + k] = d[8*(7-k) +: 8];
            else if (k < 4) body[4 + k] = d[8*(3-k) +: 8];
        end
        while (body.size() > len) body.pop_back();
        while (body.size() < len) body.push_back($urandom_range(0, 255));
        return mk_box(TAG_MEHD, body, 0);
    endfunction

    function automatic logic [31:0] rnd_scale();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return $urandom;
            default: return $urandom_range(1, 90000);
        endcase
    endfunction

    function automatic logic [63:0] rnd_dur();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return {$urandom, $urandom};
            2: return {32'd0, $urandom};
            default: return 64'($urandom_range(0, 2000000));
        endcase
    endfunction

    function automatic logic [7:0] rnd_ver();
        return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 1));
    endfunction

    function automatic bq_t bad_header();
        logic [31:0] sz;
        sz = $urandom_range(0, 1) ? $urandom_range(0, 7) : 32'h7FFF0000 | $urandom;
        return {be({32'd0, sz}, 4), be({32'd0, $urandom}, 4)};
    endfunction

    function automatic bq_t rand_mvex();
        bq_t inner;
        logic [7:0] v;
        int len;
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    v = rnd_ver();
                    len = (v == 1) ? 12 : 8;
                    if ($urandom_range(0, 4) == 0) len = $urandom_range(0, 14);
                    inner = {inner, mk_mehd(v, rnd_dur(), len)};
                end
                3, 4: inner = {inner, mk_box($urandom, rnd_bytes($urandom_range(0, 6)), 0)};
                default: inner = {inner, bad_header()};
            endcase
        end
        return mk_box(TAG_MVEX, inner, 0);
    endfunction

    function automatic bq_t rand_file();
        bq_t f, moov, t;
        int kind;
        repeat ($urandom_range(0, 2))
            f = {f, mk_box(32'h66726565 ^ ($urandom & 32'h0101_0101),
                           rnd_bytes($urandom_range(0, 12)), $urandom_range(0, 3) == 0)};
        kind = $urandom_range(0, 19);
        if (kind < 15) begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: moov = {moov, mk_mvhd(rnd_ver(), rnd_scale(), rnd_dur(),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                    : 32 + $urandom_range(0, 8))};
                    4, 5, 6: moov = {moov, rand_mvex()};
                    7, 8: moov = {moov, mk_box($urandom, rnd_bytes($urandom_range(0, 10)), 0)};
                    default: moov = {moov, bad_header()};
                endcase
            end
            if ($urandom_range(0, 5) == 0) moov = {moov, rnd_bytes($urandom_range(1, 7))};
            f = {f, mk_box(TAG_MOOV, moov, $urandom_range(0, 5) == 0)};
        end else if (kind < 17) begin
            if ($urandom_range(0, 1))
                t = {be(1, 4), be({32'd0, $urandom}, 4), be(64'($urandom_range(0, 15)), 8)};
            else
                t = {be(64'($urandom_range(0, 7)), 4), be({32'd0, $urandom}, 4)};
            f = {f, t};
        end else if (kind == 17) begin
            f = {f, rnd_bytes($urandom_range(1, 30))};
        end
        if ($urandom_range(0, 3) == 0) f = {f, rnd_bytes($urandom_range(1, 10))};
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(0, f.size() / 2)) f.pop_back();
        if (f.size() == 0) f.push_back($urandom_range(0, 255));
        return f;
    endfunction

    // stream side
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= b;
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_file(input bq_t f);
        foreach (f[k]) send_byte(f[k], k == f.size() - 1);
    endtask

    task automatic wait_results();
        i_s_tvalid <= 0;
        while (dur_expected.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        wait_results();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        limit_ms = v;
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        dur_result_t e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (dur_expected.size() == 0) begin
                report($sformatf("unexpected beat ms=%0d st=%0d", o_m_tdata, o_m_tuser));
            end else begin
                e = dur_expected.pop_front();
                if (o_m_tdata !== e.ms)
                    report($sformatf("duration %0d, want %0d", o_m_tdata, e.ms));
                if (o_m_tuser !== e.st)
                    report($sformatf("status %0d, want %0d", o_m_tuser, e.st));
            end
        end
    end

    task automatic test_directed();
        bq_t mv;
        send_file(mk_box(TAG_MOOV, mk_mvhd(0, 1000, 5000, 32), 0));
        send_file(mk_box(TAG_MOOV, mk_mvhd(1, 48000, 64'h0000_0001_0000_0000, 32), 0));
        send_file(mk_box(TAG_MOOV, mk_mvhd(0, 0, 1234, 32), 0));             // timescale zero
        send_file(mk_box(TAG_MOOV, mk_mvhd(0, 1, 32'hFFFF_FFFF, 32), 0));    // over limit
        send_file(mk_box(TAG_MOOV, {mk_mvhd(0, 600, 0, 32),
                  mk_box(TAG_MVEX, mk_mehd(0, 9000, 8), 0)}, 0));         // fragment only
        send_file(mk_box(TAG_MOOV, {mk_box(TAG_MVEX, mk_mehd(1, 64'hFFFF_FFFF_FFFF_FFFF, 12), 0),
                  mk_mvhd(1, 32'hFFFF_FFFF, 0, 32)}, 0));
        send_file({mk_box(32'h66747970, rnd_bytes(4), 1),
                   mk_box(TAG_MOOV, mk_mvhd(2, 90000, 900000, 40), 1)});    // extended sizes
        send_file({be(0, 4), be(32'h66726565, 4)});                           // size zero
        send_file({be(5, 4), be(32'h66726565, 4), rnd_bytes(3)});
        send_file({be(1, 4), be({32'd0, TAG_MOOV}, 4), be(15, 8)});
        send_file(mk_box(32'h66726565, rnd_bytes(6), 0));                     // no moov
        send_file({8'hFF});
        send_file(mk_box(TAG_MOOV, {mk_mvhd(0, 1000, 777, 32), bad_header(), rnd_bytes(8)}, 0));
        send_file(mk_box(TAG_MOOV, {mk_mvhd(0, 1000, 0, 32),
                  mk_box(TAG_MVEX, {bad_header(), mk_mehd(0, 55, 8)}, 0)}, 0));
        send_file(mk_box(TAG_MOOV, mk_mvhd(1, 1000, 4444, 26), 0));          // fields cut short
        send_file(mk_box(TAG_MOOV, mk_mvhd(0, 1000, 4444, 14), 0));
        send_file({mk_box(TAG_MOOV, {mk_mvhd(0, 10, 3, 32), rnd_bytes(5)}, 0),
                   rnd_bytes(12)});                                          // trailing bytes
        mv = {};
        send_file(mk_box(TAG_MOOV, mv, 0));
    endtask

    task automatic test_limit_settings();
        logic [31:0] lims[5];
        lims = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1000, MAX_DURATION_RESET};
        foreach (lims[k]) begin
            write_limit(lims[k]);
            send_file(mk_box(TAG_MOOV, mk_mvhd(0, 1000, 1000, 32), 0));
            send_file(mk_box(TAG_MOOV, mk_mvhd(1, 1, 64'h0000_0000_FFFF_FFFF, 32), 0));
        end
    endtask

    task automatic test_random_phases();
        int idles[4] = '{0, 81, 0, 27};
        int stalls[4] = '{0, 0, 81, 27};
        int stop;
        for (int p = 0; p < 4; p++) begin
            wait_results();     // every result in before the next phase starts
            idle_pct = idles[p];
            stall_pct = stalls[p];
            if (p == 2) write_limit($urandom);
            if (p == 3) write_limit(MAX_DURATION_RESET);
            stop = bytes_sent + 40;
            while (bytes_sent < stop) send_file(rand_file());
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        i_clk = 0;
        i_rst_n <= 0;
        i_s_tvalid <= 0;
        i_s_tdata <= 0;
        i_s_tlast <= 0;
        i_m_tready <= 0;
        i_cfg_we <= 0;
        i_cfg_wdata <= 0;
        limit_ms = MAX_DURATION_RESET;
        clear_parser();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_limit_settings();
        test_random_phases();
        wait_results();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
